>>> hw/rtl/smm_pkg.sv
package smm_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_INPUTS   = 16;
   localparam int DEF_MAX_OUTPUTS  = 16;
   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_COEF_WIDTH   = 16;

   // Fixed field and datapath widths
   localparam int ACTION_WIDTH = 2;
   localparam int STORE_DEPTH  = 256;
   localparam int STORE_AW     = 8;
   localparam int ROW_SHIFT    = 4;    // address = row * 16 + column
   localparam int CFG_WIDTH    = 5;
   localparam int POS_WIDTH    = 5;
   localparam int ACC_WIDTH    = 40;
   localparam int FRAC_BITS    = 14;
   localparam int OUT_WIDTH    = 24;
   localparam int CHAN_WIDTH   = 4;

   // Item actions
   localparam logic [ACTION_WIDTH-1:0] ACT_LOAD    = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_SAMPLE  = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_RESTART = 2'd2;

   // Register indexes of the configuration port
   typedef enum logic [0:0] {
      CSR_INPUT_COUNT  = 1'b0,
      CSR_OUTPUT_COUNT = 1'b1
   } csr_index_type;

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic mul_valid;   // coefficient on the bus is valid for mul_row
      logic clear;       // zero every accumulator
   } mac_ctrl_type;

endpackage

>>> hw/rtl/smm_if.sv
interface smm_req_if import smm_pkg::*; #(
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
);
   logic                           valid;
   logic                           ready;
   logic [ACTION_WIDTH-1:0]        action;
   logic [STORE_AW-1:0]            coef_index;
   logic signed [COEF_WIDTH-1:0]   coef_value;
   logic signed [SAMPLE_WIDTH-1:0] sample_value;

   modport source (output valid, action, coef_index, coef_value, sample_value, input ready);
   modport sink   (input valid, action, coef_index, coef_value, sample_value, output ready);
endinterface

interface smm_rsp_if import smm_pkg::*;;
   logic                        valid;
   logic                        ready;
   logic [CHAN_WIDTH-1:0]       out_channel;
   logic signed [OUT_WIDTH-1:0] out_value;
   logic                        clipped;
   logic                        last;

   modport source (output valid, out_channel, out_value, clipped, last, input ready);
   modport sink   (input valid, out_channel, out_value, clipped, last, output ready);
endinterface

>>> hw/rtl/spatial_filter_matrix_mac_unit.sv
// Load, restart and unused items are taken in the idle state, which stays ready.
// Sample item: one coefficient read and one multiply-accumulate per output row
//   through the single MAC, then the RAM read and product stages drain.
// Completing sample: hands out one result beat per row, waiting on back-pressure.
// Synchronous reset clears the counts to 1, the position and the accumulators;
//   the coefficient store keeps whatever it held and must be loaded before use.
module spatial_filter_matrix_mac_unit import smm_pkg::*; #(
   parameter int MAX_INPUTS   = DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS  = DEF_MAX_OUTPUTS,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   smm_req_if.sink              req_bus,
   smm_rsp_if.source            rsp_bus,
   input  logic                 csr_write_en,
   input  csr_index_type        csr_index,
   input  logic [CFG_WIDTH-1:0] csr_wdata
);

   localparam int ROW_W  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int OCNT_W = $clog2(MAX_OUTPUTS + 1);
   localparam int ICNT_W = $clog2(MAX_INPUTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   // Sequencer state
   state_type                      state_ff, state_in;
   logic [CFG_WIDTH-1:0]           in_count_ff, in_count_in;
   logic [CFG_WIDTH-1:0]           out_count_ff, out_count_in;
   logic [POS_WIDTH-1:0]           pos_ff, pos_in;
   logic [POS_WIDTH-1:0]           col_ff, col_in;
   logic                           finish_ff, finish_in;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [OCNT_W-1:0]              issue_ff, issue_in;
   logic                           rd_valid_ff, rd_valid_in;
   logic [ROW_W-1:0]               rd_row_ff, rd_row_in;
   logic [OCNT_W-1:0]              emit_ff, emit_in;

   // Result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [CHAN_WIDTH-1:0]          rsp_chan_ff, rsp_chan_in;
   logic signed [OUT_WIDTH-1:0]    rsp_value_ff, rsp_value_in;
   logic                           rsp_clip_ff, rsp_clip_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [ICNT_W-1:0]              n_in;
   logic [OCNT_W-1:0]              n_out;
   logic                           accept;
   logic [POS_WIDTH-1:0]           pos_next;
   logic                           ends_sample;
   logic                           issue_go;
   logic                           emit_last;

   logic                           ram_wr_en;
   logic                           ram_rd_en;
   logic [STORE_AW-1:0]            ram_rd_addr;
   logic [COEF_WIDTH-1:0]          ram_rd_data;

   mac_ctrl_type                   mac_ctrl;
   logic signed [OUT_WIDTH-1:0]    mac_value;
   logic                           mac_clip;
   logic                           mac_busy;

   // Clamp the programmed counts: zero acts as one, large values as the maximum
   always_comb begin
      if (in_count_ff == '0) begin
         n_in = ICNT_W'(1);
      end else if (int'(in_count_ff) > MAX_INPUTS) begin
         n_in = ICNT_W'(MAX_INPUTS);
      end else begin
         n_in = ICNT_W'(in_count_ff);
      end
      if (out_count_ff == '0) begin
         n_out = OCNT_W'(1);
      end else if (int'(out_count_ff) > MAX_OUTPUTS) begin
         n_out = OCNT_W'(MAX_OUTPUTS);
      end else begin
         n_out = OCNT_W'(out_count_ff);
      end
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // A sample closes when the position wraps or reaches the input count
   assign pos_next    = pos_ff + POS_WIDTH'(1);
   assign ends_sample = (pos_next == '0) || (int'(pos_next) >= int'(n_in));

   assign issue_go  = (state_ff == ST_MAC) && (issue_ff < n_out);
   assign emit_last = (emit_ff + OCNT_W'(1)) == n_out;

   // Coefficient address is row * 16 + column, wrapped to the store
   assign ram_wr_en   = accept && (req_bus.action == ACT_LOAD);
   assign ram_rd_en   = issue_go;
   assign ram_rd_addr = STORE_AW'((STORE_AW'(issue_ff[ROW_W-1:0]) << ROW_SHIFT)
                                  + STORE_AW'(col_ff));

   always_comb begin
      state_in     = state_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      pos_in       = pos_ff;
      col_in       = col_ff;
      finish_in    = finish_ff;
      sample_in    = sample_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_row_in    = rd_row_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_chan_in  = rsp_chan_ff;
      rsp_value_in = rsp_value_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_last_in  = rsp_last_ff;
      mac_ctrl     = '0;

      if (csr_write_en) begin
         case (csr_index)
            CSR_INPUT_COUNT:  in_count_in  = csr_wdata;
            CSR_OUTPUT_COUNT: out_count_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.action)
                  ACT_SAMPLE: begin
                     // Latch the sample and column, advance the position
                     sample_in = req_bus.sample_value;
                     col_in    = pos_ff;
                     finish_in = ends_sample;
                     pos_in    = ends_sample ? '0 : pos_next;
                     issue_in  = '0;
                     state_in  = ST_MAC;
                  end
                  ACT_RESTART: begin
                     pos_in        = '0;
                     mac_ctrl.clear = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MAC: begin
            // Issue one row a cycle, then drain the read and product stages
            if (issue_go) begin
               rd_valid_in = 1'b1;
               rd_row_in   = issue_ff[ROW_W-1:0];
               issue_in    = issue_ff + OCNT_W'(1);
            end else if (!rd_valid_ff && !mac_busy) begin
               emit_in  = '0;
               state_in = finish_ff ? ST_EMIT : ST_IDLE;
            end
            mac_ctrl.mul_valid = rd_valid_ff;
         end
         ST_EMIT: begin
            // Load the next result beat once the register is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = CHAN_WIDTH'(emit_ff);
               rsp_value_in = mac_value;
               rsp_clip_in  = mac_clip;
               rsp_last_in  = emit_last;
               emit_in      = emit_ff + OCNT_W'(1);
               if (emit_last) begin
                  mac_ctrl.clear = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_count_ff  <= CFG_WIDTH'(1);
         out_count_ff <= CFG_WIDTH'(1);
         pos_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         finish_ff    <= 1'b0;
         issue_ff     <= '0;
         emit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         pos_ff       <= pos_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         finish_ff    <= finish_in;
         issue_ff     <= issue_in;
         emit_ff      <= emit_in;
      end
      col_ff       <= col_in;
      sample_ff    <= sample_in;
      rd_row_ff    <= rd_row_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_value_ff <= rsp_value_in;
      rsp_clip_ff  <= rsp_clip_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_chan_ff;
   assign rsp_bus.out_value   = rsp_value_ff;
   assign rsp_bus.clipped     = rsp_clip_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // Coefficient store
   smm_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_bus.coef_index),
      .wr_data (req_bus.coef_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared multiply-accumulate unit and row accumulators
   smm_mac #(
      .MAX_OUTPUTS  (MAX_OUTPUTS),
      .COEF_WIDTH   (COEF_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .mul_row   (rd_row_ff),
      .coef      ($signed(ram_rd_data)),
      .sample    (sample_ff),
      .rd_row    (emit_ff[ROW_W-1:0]),
      .out_value (mac_value),
      .clipped   (mac_clip),
      .busy      (mac_busy)
   );

endmodule

>>> hw/rtl/smm_ram.sv
module smm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hw/rtl/smm_mac.sv
module smm_mac import smm_pkg::*; #(
   parameter int MAX_OUTPUTS  = DEF_MAX_OUTPUTS,
   parameter int COEF_WIDTH   = DEF_COEF_WIDTH,
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   localparam int ROW_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctrl_type                   ctrl,
   input  logic [ROW_W-1:0]               mul_row,
   input  logic signed [COEF_WIDTH-1:0]   coef,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic [ROW_W-1:0]               rd_row,
   output logic signed [OUT_WIDTH-1:0]    out_value,
   output logic                           clipped,
   output logic                           busy
);

   localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int QW     = ACC_WIDTH - FRAC_BITS;

   logic signed [PROD_W-1:0]  prod_ff;
   logic [ROW_W-1:0]          prod_row_ff;
   logic                      prod_valid_ff;
   logic [ACC_WIDTH-1:0]      acc_ff [MAX_OUTPUTS];

   logic [ACC_WIDTH-1:0]      acc_sel;
   logic [QW-1:0]             quot;
   logic [QW-OUT_WIDTH:0]     quot_hi;
   logic                      over;

   // Product stage, then accumulate into the addressed row
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         for (int r = 0; r < MAX_OUTPUTS; r++) begin
            acc_ff[r] <= '0;
         end
      end else begin
         prod_valid_ff <= ctrl.mul_valid;
         if (ctrl.clear) begin
            for (int r = 0; r < MAX_OUTPUTS; r++) begin
               acc_ff[r] <= '0;
            end
         end else if (prod_valid_ff) begin
            acc_ff[prod_row_ff] <= acc_ff[prod_row_ff] + ACC_WIDTH'(prod_ff);
         end
      end
      prod_ff     <= coef * sample;
      prod_row_ff <= mul_row;
   end

   // Floor shift by the fraction bits, then clamp to the output range
   always_comb begin
      acc_sel = acc_ff[rd_row];
      quot    = acc_sel[ACC_WIDTH-1:FRAC_BITS];
      quot_hi = quot[QW-1:OUT_WIDTH-1];
      over    = !((&quot_hi) || !(|quot_hi));
      if (over) begin
         out_value = quot[QW-1] ? $signed({1'b1, {(OUT_WIDTH-1){1'b0}}})
                                : $signed({1'b0, {(OUT_WIDTH-1){1'b1}}});
      end else begin
         out_value = $signed(quot[OUT_WIDTH-1:0]);
      end
      clipped = over;
   end

   assign busy = prod_valid_ff;

endmodule
